/* rtl/tfq_pkg.sv */
// Package for the transmit frame queue: request and result types, action codes,
// controller states and the command and status bundles between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package tfq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_FRAME_DEF   = 20;

  // Action codes carried by an input request.
  localparam logic [1:0] ACT_ORDERED  = 2'd0;
  localparam logic [1:0] ACT_POSITION = 2'd1;
  localparam logic [1:0] ACT_DONE     = 2'd2;

  // One input request.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One transmitted byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       from_slot;
  } tx_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY_FIRST,
    ST_COPY,
    ST_START,
    ST_EMIT_FIRST,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_byte;
    logic finish_frame;
    logic push_ordered;
    logic store_position;
    logic release_link;
    logic copy_first;
    logic copy_step;
    logic start_fifo;
    logic start_slot;
    logic emit_first;
    logic emit_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic asm_full;
    logic asm_overflow;
    logic fifo_full;
    logic fifo_empty;
    logic slot_valid;
    logic link_busy;
    logic copy_last;
    logic emit_last;
    logic tx_free;
  } status_t;

endpackage

/* rtl/tfq_datapath.sv */
// Datapath of the transmit frame queue: frame memory, queue pointers, slot and
// link flags, copy and emit counters, and the output register.
// Depends on tfq_pkg; driven by commands from tfq_controller.
module tfq_datapath #(
  parameter int QUEUE_DEPTH = tfq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_FRAME   = tfq_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  tfq_pkg::cmd_t     cmd,
  output tfq_pkg::status_t  status,
  input  logic              tx_ready,
  output logic              tx_valid,
  output tfq_pkg::tx_item_t tx
);
  import tfq_pkg::*;

  // Memory rows: one per queue entry, then the slot row, then the assembly row.
  localparam int ROWS  = QUEUE_DEPTH + 2;
  localparam int DEPTH = ROWS * MAX_FRAME;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int IW    = $clog2(MAX_FRAME);
  localparam int LW    = $clog2(MAX_FRAME + 1);
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RW-1:0] ROW_SLOT  = RW'(QUEUE_DEPTH);
  localparam logic [RW-1:0] ROW_ASM   = RW'(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] ASM_FULL  = LW'(MAX_FRAME);
  localparam logic [QW-1:0] LAST_Q    = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] QUEUE_MAX = CW'(QUEUE_DEPTH);

  // Each memory word holds a frame byte and its end-of-frame mark.
  logic [8:0]    mem [DEPTH];
  logic [8:0]    rd_q;

  logic [LW-1:0] asm_count;
  logic          asm_overflow;
  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [CW-1:0] entries;
  logic          slot_valid;
  logic          link_busy;
  logic [IW-1:0] idx;
  logic [IW-1:0] last_idx;
  logic [RW-1:0] dst_row;
  logic [RW-1:0] src_row;
  logic          from_slot;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [8:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] idx_inc;
  logic [AW-1:0] asm_base;
  logic [AW-1:0] dst_base;
  logic [AW-1:0] src_base;

  // Row base addresses.
  assign asm_base = AW'(ROW_ASM) * AW'(MAX_FRAME);
  assign dst_base = AW'(dst_row) * AW'(MAX_FRAME);
  assign src_base = AW'(src_row) * AW'(MAX_FRAME);
  assign idx_inc  = idx + IW'(1);

  // Write port: incoming bytes go to the assembly row, copy steps to the target row.
  always_comb begin
    wr_en   = (cmd.accept_byte && (asm_count != ASM_FULL)) || cmd.copy_step;
    wr_addr = asm_base + AW'(asm_count[IW-1:0]);
    wr_data = {1'b0, data_byte};
    if (cmd.copy_step) begin
      wr_addr = dst_base + AW'(idx);
      wr_data = {idx == last_idx, rd_q[7:0]};
    end
  end

  // Read port: the copy walks the assembly row, emission walks the source row.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = asm_base;
    priority if (cmd.copy_first) begin
      rd_en   = 1'b1;
      rd_addr = asm_base;
    end else if (cmd.copy_step) begin
      rd_en   = (idx != last_idx);
      rd_addr = asm_base + AW'(idx_inc);
    end else if (cmd.emit_first) begin
      rd_en   = 1'b1;
      rd_addr = src_base;
    end else if (cmd.emit_step) begin
      rd_en   = !rd_q[8];
      rd_addr = src_base + AW'(idx_inc);
    end
  end

  // Frame memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Control registers: assembly, queue, slot and link state.
  always_ff @(posedge clk) begin
    if (rst) begin
      asm_count    <= '0;
      asm_overflow <= 1'b0;
      head         <= '0;
      tail         <= '0;
      entries      <= '0;
      slot_valid   <= 1'b0;
      link_busy    <= 1'b0;
      from_slot    <= 1'b0;
    end else begin
      if (cmd.accept_byte) begin
        if (asm_count == ASM_FULL) begin
          asm_overflow <= 1'b1;
        end else begin
          asm_count <= asm_count + LW'(1);
        end
      end
      if (cmd.finish_frame) begin
        asm_count    <= '0;
        asm_overflow <= 1'b0;
      end
      // An ordered frame always cancels the slot, even when the queue is full.
      if (cmd.push_ordered) begin
        slot_valid <= 1'b0;
        if (entries != QUEUE_MAX) begin
          tail    <= (tail == LAST_Q) ? '0 : tail + QW'(1);
          entries <= entries + CW'(1);
        end
      end
      if (cmd.store_position) begin
        slot_valid <= 1'b1;
      end
      if (cmd.release_link) begin
        link_busy <= 1'b0;
      end
      if (cmd.start_fifo) begin
        head      <= (head == LAST_Q) ? '0 : head + QW'(1);
        entries   <= entries - CW'(1);
        link_busy <= 1'b1;
        from_slot <= 1'b0;
      end
      if (cmd.start_slot) begin
        slot_valid <= 1'b0;
        link_busy  <= 1'b1;
        from_slot  <= 1'b1;
      end
    end
  end

  // Copy and emit bookkeeping; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.finish_frame) begin
      last_idx <= asm_count[IW-1:0];
    end
    if (cmd.push_ordered) begin
      dst_row <= RW'(tail);
    end
    if (cmd.store_position) begin
      dst_row <= ROW_SLOT;
    end
    if (cmd.start_fifo) begin
      src_row <= RW'(head);
    end
    if (cmd.start_slot) begin
      src_row <= ROW_SLOT;
    end
    if (cmd.copy_first || cmd.emit_first) begin
      idx <= '0;
    end else if (cmd.copy_step || (cmd.emit_step && !rd_q[8])) begin
      idx <= idx_inc;
    end
  end

  // Output register decouples emission from the downstream ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      tx.out_byte  <= rd_q[7:0];
      tx.out_last  <= rd_q[8];
      tx.from_slot <= from_slot;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.asm_full     = (asm_count == ASM_FULL);
    status.asm_overflow = asm_overflow;
    status.fifo_full    = (entries == QUEUE_MAX);
    status.fifo_empty   = (entries == '0);
    status.slot_valid   = slot_valid;
    status.link_busy    = link_busy;
    status.copy_last    = (idx == last_idx);
    status.emit_last    = rd_q[8];
    status.tx_free      = !tx_valid || tx_ready;
  end

endmodule

/* rtl/tfq_controller.sv */
// Controller of the transmit frame queue: accepts requests, sequences the frame
// copy into the queue or slot, picks the next frame and paces its emission.
// Depends on tfq_pkg; drives tfq_datapath through the command bundle.
module tfq_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [1:0]       action,
  input  logic             last_byte,
  input  tfq_pkg::status_t status,
  output tfq_pkg::cmd_t    cmd
);
  import tfq_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   frame_ok;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept   = item_valid && item_ready;
  // A frame is kept only if every byte, including this final one, fit the buffer.
  assign frame_ok = !status.asm_overflow && !status.asm_full;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (accept) begin
          unique case (action)
            ACT_DONE: begin
              cmd.release_link = 1'b1;
              state_next       = ST_START;
            end
            ACT_ORDERED, ACT_POSITION: begin
              cmd.accept_byte = 1'b1;
              if (last_byte) begin
                cmd.finish_frame = 1'b1;
                if (frame_ok) begin
                  if (action == ACT_ORDERED) begin
                    cmd.push_ordered = 1'b1;
                    state_next = status.fifo_full ? ST_START : ST_COPY_FIRST;
                  end else begin
                    cmd.store_position = 1'b1;
                    state_next         = ST_COPY_FIRST;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_COPY_FIRST: begin
        cmd.copy_first = 1'b1;
        state_next     = ST_COPY;
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.copy_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        priority if (status.link_busy) begin
          state_next = ST_IDLE;
        end else if (!status.fifo_empty) begin
          cmd.start_fifo = 1'b1;
          state_next     = ST_EMIT_FIRST;
        end else if (status.slot_valid) begin
          cmd.start_slot = 1'b1;
          state_next     = ST_EMIT_FIRST;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_FIRST: begin
        cmd.emit_first = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.tx_free) begin
          cmd.emit_step = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/tx_frame_queue_with_latest_slot.sv */
// Top level of the transmit frame queue with a latest-position slot.
// Depends on tfq_pkg, tfq_controller and tfq_datapath.
//
//   Channel   Signals                          Carries
//   request   item_valid, item_ready, item     frame byte, last mark, or done
//   transmit  tx_valid, tx_ready, tx           one byte of the frame being sent
//
// A request is taken only in the idle state. A kept frame is then copied from
// the assembly row of the frame memory byte by byte (one memory read port).
// If the link is free a frame is started, queue head before slot, and its bytes
// leave one by one as the transmit side takes them; request ready stays low until
// the last byte is in the output register. Reset is synchronous; the memory needs no clearing.
module tx_frame_queue_with_latest_slot #(
  parameter int QUEUE_DEPTH = tfq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_FRAME   = tfq_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tfq_pkg::item_t    item,
  output logic              tx_valid,
  input  logic              tx_ready,
  output tfq_pkg::tx_item_t tx
);
  import tfq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  tfq_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (item.action),
    .last_byte  (item.last_byte),
    .status     (status),
    .cmd        (cmd)
  );

  // Storage and output.
  tfq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_FRAME   (MAX_FRAME)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (item.data_byte),
    .cmd       (cmd),
    .status    (status),
    .tx_ready  (tx_ready),
    .tx_valid  (tx_valid),
    .tx        (tx)
  );

endmodule
